@@ rtl/core/coe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock offset estimator package
// Shared widths, reset values and command and register codes.
// ----------------------------------------------------------------------------
package coe_pkg;

    localparam int TIME_BITS         = 48;
    localparam int OFFSET_BITS       = 49;
    localparam int SNOW_BITS         = 50;
    localparam int CMD_BITS          = 2;
    localparam int COUNT_BITS_DEF    = 32;
    localparam int SAMPLE_COUNT_BITS = 32;
    localparam int FACTOR_BITS       = 4;
    localparam int SHIFT_BITS        = 3;
    localparam int MAX_SHIFT         = (1 << SHIFT_BITS) - 1;
    localparam int CFG_IDX_BITS      = 2;
    localparam int CFG_DATA_BITS     = 4;

    localparam logic [FACTOR_BITS-1:0] REJECT_FACTOR_RST   = 4'd4;
    localparam logic [SHIFT_BITS-1:0]  SMOOTHING_SHIFT_RST = 3'd2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PING  = 2'd0,
        CMD_PONG  = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_REJECT_FACTOR   = 2'd0,
        CFG_SMOOTHING_SHIFT = 2'd1
    } cfg_idx_t;

endpackage

@@ rtl/core/coe_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock offset estimator channels
// Valid/ready interfaces for request beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface coe_req_if;
    import coe_pkg::*;

    logic                           valid;
    logic                           ready;
    logic [CMD_BITS-1:0]            cmd;
    logic [TIME_BITS-1:0]           now_ms;
    logic signed [OFFSET_BITS-1:0]  remote_ms;

    modport source (output valid, output cmd, output now_ms, output remote_ms, input ready);
    modport sink (input valid, input cmd, input now_ms, input remote_ms, output ready);
endinterface

interface coe_rsp_if;
    import coe_pkg::*;

    logic                           valid;
    logic                           ready;
    logic                           kept;
    logic                           offset_valid;
    logic signed [OFFSET_BITS-1:0]  skew_ms;
    logic signed [SNOW_BITS-1:0]    remote_now;
    logic [TIME_BITS-1:0]           recent_rtt;
    logic [SAMPLE_COUNT_BITS-1:0]   sample_count;

    modport source (output valid, output kept, output offset_valid, output skew_ms,
                    output remote_now, output recent_rtt, output sample_count,
                    input ready);
    modport sink (input valid, input kept, input offset_valid, input skew_ms,
                  input remote_now, input recent_rtt, input sample_count,
                  output ready);
endinterface

interface coe_cfg_if;
    import coe_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_IDX_BITS-1:0]   index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/clock_offset_estimator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock offset estimator
// Tracks the server minus local clock offset from ping and pong beats with
// round trip rejection and an exponential moving average; query beats only report.
// ----------------------------------------------------------------------------
// A request beat passes through one input register and one result register,
// with the offset update done between them.
// Throughput is one beat per cycle while the result side accepts; the state update loop sets it.
// Reset clears the pending flag, offset, counts and holds best round trip at
// all ones; register writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
module clock_offset_estimator #(
    parameter int COUNT_BITS = coe_pkg::COUNT_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    coe_req_if.sink   req,
    coe_rsp_if.source rsp,
    coe_cfg_if.sink   cfg
);
    import coe_pkg::*;

    localparam int LIMIT_BITS  = TIME_BITS + FACTOR_BITS;
    localparam int WIDE_BITS   = OFFSET_BITS + 2;
    localparam int BLEND_BITS  = OFFSET_BITS + MAX_SHIFT + 1;

    logic [FACTOR_BITS-1:0]         reject_factor_reg;
    logic [SHIFT_BITS-1:0]          smoothing_shift_reg;

    logic                           s1_valid_reg;
    logic [CMD_BITS-1:0]            s1_cmd_reg;
    logic [TIME_BITS-1:0]           s1_now_reg;
    logic signed [OFFSET_BITS-1:0]  s1_server_reg;

    logic                           pending_reg, pending_next;
    logic [TIME_BITS-1:0]           send_time_reg, send_time_next;
    logic                           offset_seen_reg, offset_seen_next;
    logic signed [OFFSET_BITS-1:0]  offset_reg, offset_next;
    logic [TIME_BITS-1:0]           best_rtt_reg, best_rtt_next;
    logic [TIME_BITS-1:0]           last_rtt_reg, last_rtt_next;
    logic [COUNT_BITS-1:0]          used_reg, used_next;
    logic                           kept_next;

    logic                           out_valid_reg;
    logic                           out_kept_reg;
    logic                           out_have_reg;
    logic signed [OFFSET_BITS-1:0]  out_offset_reg;
    logic signed [SNOW_BITS-1:0]    out_snow_reg, snow_next;
    logic [TIME_BITS-1:0]           out_rtt_reg;
    logic [COUNT_BITS-1:0]          out_used_reg;

    logic                           advance;
    logic                           step;

    logic [TIME_BITS-1:0]           rtt;
    logic [TIME_BITS:0]             mid_sum;
    logic signed [WIDE_BITS-1:0]    sample_wide;
    logic signed [OFFSET_BITS-1:0]  sample;
    logic [LIMIT_BITS-1:0]          reject_limit;
    logic signed [BLEND_BITS-1:0]   old_wide;
    logic signed [BLEND_BITS-1:0]   blend_sum;
    logic signed [BLEND_BITS-1:0]   blend_bias;
    logic signed [BLEND_BITS-1:0]   blend_q;

    assign advance   = !out_valid_reg || rsp.ready;
    assign step      = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reject_factor_reg   <= REJECT_FACTOR_RST;
            smoothing_shift_reg <= SMOOTHING_SHIFT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_REJECT_FACTOR:   reject_factor_reg   <= cfg.data[FACTOR_BITS-1:0];
                CFG_SMOOTHING_SHIFT: smoothing_shift_reg <= cfg.data[SHIFT_BITS-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_cmd_reg    <= req.cmd;
            s1_now_reg    <= req.now_ms;
            s1_server_reg <= req.remote_ms;
        end
    end

    always_comb
    begin
        rtt          = s1_now_reg - send_time_reg;
        mid_sum      = {1'b0, send_time_reg} + {1'b0, s1_now_reg};
        sample_wide  = WIDE_BITS'(s1_server_reg) - $signed({3'b000, mid_sum[TIME_BITS:1]});
        if (sample_wide[WIDE_BITS-1:OFFSET_BITS-1] == '0
            || sample_wide[WIDE_BITS-1:OFFSET_BITS-1] == '1)
        begin
            sample = sample_wide[OFFSET_BITS-1:0];
        end
        else
        begin
            sample = {sample_wide[WIDE_BITS-1], {(OFFSET_BITS-1){!sample_wide[WIDE_BITS-1]}}};
        end

        reject_limit = LIMIT_BITS'(best_rtt_reg) * LIMIT_BITS'(reject_factor_reg);

        old_wide   = BLEND_BITS'(offset_reg);
        blend_sum  = (old_wide <<< smoothing_shift_reg) - old_wide + BLEND_BITS'(sample);
        blend_bias = blend_sum[BLEND_BITS-1]
                   ? ((BLEND_BITS'(1) <<< smoothing_shift_reg) - BLEND_BITS'(1))
                   : '0;
        blend_q    = (blend_sum + blend_bias) >>> smoothing_shift_reg;

        pending_next     = pending_reg;
        send_time_next   = send_time_reg;
        offset_seen_next = offset_seen_reg;
        offset_next      = offset_reg;
        best_rtt_next    = best_rtt_reg;
        last_rtt_next    = last_rtt_reg;
        used_next        = used_reg;
        kept_next        = 1'b0;

        case (s1_cmd_reg)
            CMD_PING:
            begin
                send_time_next = s1_now_reg;
                pending_next   = 1'b1;
            end
            CMD_PONG:
            begin
                if (pending_reg && s1_server_reg > 0)
                begin
                    pending_next  = 1'b0;
                    last_rtt_next = rtt;
                    if (!offset_seen_reg)
                    begin
                        offset_next      = sample;
                        offset_seen_next = 1'b1;
                        best_rtt_next    = rtt;
                        used_next        = COUNT_BITS'(1);
                        kept_next        = 1'b1;
                    end
                    else if (LIMIT_BITS'(rtt) <= reject_limit)
                    begin
                        if (rtt < best_rtt_reg)
                        begin
                            best_rtt_next = rtt;
                        end
                        offset_next = blend_q[OFFSET_BITS-1:0];
                        if (used_reg != '1)
                        begin
                            used_next = used_reg + COUNT_BITS'(1);
                        end
                        kept_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        snow_next = offset_seen_next
                  ? ($signed({2'b00, s1_now_reg}) + SNOW_BITS'(offset_next))
                  : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg     <= 1'b0;
            send_time_reg   <= '0;
            offset_seen_reg <= 1'b0;
            offset_reg      <= '0;
            best_rtt_reg    <= '1;
            last_rtt_reg    <= '0;
            used_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                pending_reg     <= pending_next;
                send_time_reg   <= send_time_next;
                offset_seen_reg <= offset_seen_next;
                offset_reg      <= offset_next;
                best_rtt_reg    <= best_rtt_next;
                last_rtt_reg    <= last_rtt_next;
                used_reg        <= used_next;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_kept_reg   <= kept_next;
            out_have_reg   <= offset_seen_next;
            out_offset_reg <= offset_next;
            out_snow_reg   <= snow_next;
            out_rtt_reg    <= last_rtt_next;
            out_used_reg   <= used_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.kept          = out_kept_reg;
    assign rsp.offset_valid  = out_have_reg;
    assign rsp.skew_ms       = out_offset_reg;
    assign rsp.remote_now    = out_snow_reg;
    assign rsp.recent_rtt    = out_rtt_reg;

    generate
        if (COUNT_BITS >= SAMPLE_COUNT_BITS)
        begin : g_count_wide
            assign rsp.sample_count = out_used_reg[SAMPLE_COUNT_BITS-1:0];
        end
        else
        begin : g_count_narrow
            assign rsp.sample_count = SAMPLE_COUNT_BITS'(out_used_reg);
        end
    endgenerate

    // The sample count is nonzero exactly when an offset has been loaded.
    a_count_tracks_offset: assert property (@(posedge clk) disable iff (!rst_n)
        offset_seen_reg == (used_reg != '0))
        else $error("sample count disagrees with offset valid flag");

    // Once an offset exists the best round trip can only shrink.
    a_best_rtt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        $past(offset_seen_reg) |-> best_rtt_reg <= $past(best_rtt_reg))
        else $error("best round trip increased");

    // A kept sample consumes the pending exchange.
    a_kept_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        step && kept_next |=> !pending_reg)
        else $error("pending exchange survived a kept sample");

    // A result with a kept sample always reports a valid offset.
    a_kept_has_offset: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.kept |-> rsp.offset_valid)
        else $error("kept result without a valid offset");

endmodule
